// ----- design/bma_pkg.sv -----
// Shared constants, types and helpers for the boxcar moving average block.
`default_nettype none
package bma_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int SUM_BITS     = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int IDX_BITS     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_BITS     = $clog2(MAX_WINDOW + 1);
    localparam int CFG_BITS     = 7;
    localparam int STEP_BITS    = $clog2(SUM_BITS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(16);

    // Request codes
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Saturation bounds of the quotient magnitude
    localparam logic [SUM_BITS-1:0] SAT_POS = SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [SUM_BITS-1:0] SAT_NEG = SUM_BITS'(64'd1 << (SAMPLE_BITS - 1));

    typedef struct packed {
        logic                          is_clear;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic                 valid;
        logic [QCNT_BITS-1:0] count;
    } t_q_status;

    // Map the configured length onto 1..MAX_WINDOW
    function automatic logic [CNT_BITS-1:0] eff_window(input logic [CFG_BITS-1:0] cfg);
        logic [CNT_BITS-1:0] w;
        if (cfg == '0) begin
            w = CNT_BITS'(1);
        end else if (32'(cfg) > 32'(MAX_WINDOW)) begin
            w = CNT_BITS'(MAX_WINDOW);
        end else begin
            w = CNT_BITS'(cfg);
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- design/bma_front.sv -----
// Input queue: accepts and classifies request items ahead of the engine.
`default_nettype none
module bma_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic                                  i_req_type,
    input  wire logic signed [bma_pkg::SAMPLE_BITS-1:0] i_sample,
    output bma_pkg::t_item                             o_item,
    output bma_pkg::t_q_status                         o_status,
    input  wire logic                                  i_pop
);

    bma_pkg::t_item                    r_slot [bma_pkg::QUEUE_DEPTH];
    logic [bma_pkg::QPTR_BITS-1:0]     r_wptr, n_wptr;
    logic [bma_pkg::QPTR_BITS-1:0]     r_rptr, n_rptr;
    logic [bma_pkg::QCNT_BITS-1:0]     r_cnt, n_cnt;
    logic                              push;
    logic                              pop;

    assign o_stall = (r_cnt == bma_pkg::QCNT_BITS'(bma_pkg::QUEUE_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != '0);

    assign o_item          = r_slot[r_rptr];
    assign o_status.valid  = (r_cnt != '0);
    assign o_status.count  = r_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (push) begin
            n_wptr = (r_wptr == bma_pkg::QPTR_BITS'(bma_pkg::QUEUE_DEPTH - 1)) ? '0
                     : r_wptr + bma_pkg::QPTR_BITS'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == bma_pkg::QPTR_BITS'(bma_pkg::QUEUE_DEPTH - 1)) ? '0
                     : r_rptr + bma_pkg::QPTR_BITS'(1);
        end
        n_cnt  = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + bma_pkg::QCNT_BITS'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - bma_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Classify on entry: sample is dropped for a clear
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr].is_clear <= (i_req_type == bma_pkg::REQ_CLEAR);
            r_slot[r_wptr].sample   <= (i_req_type == bma_pkg::REQ_CLEAR) ? '0 : i_sample;
        end
    end

endmodule
`default_nettype wire

// ----- design/bma_back.sv -----
// Engine: ring store, running sum, bit-serial divider and result register.
`default_nettype none
module bma_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [bma_pkg::CNT_BITS-1:0]          i_window,
    input  wire bma_pkg::t_item                        i_item,
    input  wire bma_pkg::t_q_status                    i_status,
    output logic                                       o_pop,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [bma_pkg::SAMPLE_BITS-1:0]     o_average,
    output logic [bma_pkg::CNT_BITS-1:0]               o_sample_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam int SB = bma_pkg::SAMPLE_BITS;
    localparam int WB = bma_pkg::SUM_BITS;
    localparam int CB = bma_pkg::CNT_BITS;

    logic signed [SB-1:0]             mem [bma_pkg::MAX_WINDOW];
    logic signed [SB-1:0]             r_rd_data;
    logic                             mem_we;

    logic [1:0]                       r_state, n_state;
    logic [bma_pkg::IDX_BITS-1:0]     r_widx;
    logic [CB-1:0]                    r_cnt;
    logic signed [WB-1:0]             r_sum;
    logic                             r_full;
    logic signed [SB-1:0]             r_sample;

    logic [WB-1:0]                    r_quo;
    logic [CB-1:0]                    r_rem;
    logic                             r_neg;
    logic [bma_pkg::STEP_BITS-1:0]    r_step;

    logic                             r_out_valid;
    logic signed [SB-1:0]             r_avg;
    logic [CB-1:0]                    r_ocnt;

    logic signed [WB-1:0]             n_sum;
    logic [WB-1:0]                    n_mag;
    logic [CB:0]                      n_widx;
    logic [CB:0]                      trial;
    logic                             q_bit;
    logic signed [SB-1:0]             sat_avg;
    logic                             out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && i_status.valid;
    assign mem_we   = o_pop && !i_item.is_clear;

    always_comb begin
        n_sum = r_sum + WB'(r_sample);
        if (r_full) begin
            n_sum = n_sum - WB'(r_rd_data);
        end
        n_mag  = n_sum[WB-1] ? WB'(-n_sum) : WB'(n_sum);
        n_widx = (CB+1)'(r_widx) + (CB+1)'(1);
    end

    // One restoring division step per cycle
    always_comb begin
        trial = {r_rem, r_quo[WB-1]};
        q_bit = (trial >= (CB+1)'(r_cnt));
    end

    always_comb begin
        if (r_neg) begin
            sat_avg = (r_quo > bma_pkg::SAT_NEG) ? SB'(bma_pkg::SAT_NEG)
                                                 : SB'(-r_quo);
        end else begin
            sat_avg = (r_quo > bma_pkg::SAT_POS) ? SB'(bma_pkg::SAT_POS) : SB'(r_quo);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_status.valid) begin
                    n_state = i_item.is_clear ? S_FIN : S_UPD;
                end
            end
            S_UPD: n_state = S_DIV;
            S_DIV: begin
                if (r_step == bma_pkg::STEP_BITS'(WB - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Read-first single port: old entry comes out as the new one goes in
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rd_data     <= mem[r_widx];
            mem[r_widx]   <= i_item.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_status.valid && i_item.is_clear) begin
                        r_widx <= '0;
                        r_cnt  <= '0;
                        r_sum  <= '0;
                    end
                end
                S_UPD: begin
                    r_sum  <= n_sum;
                    r_widx <= (n_widx >= (CB+1)'(i_window)) ? '0
                                                              : bma_pkg::IDX_BITS'(n_widx);
                    if (!r_full) begin
                        r_cnt <= r_cnt + CB'(1);
                    end
                end
                default: ;
            endcase
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sample <= i_item.sample;
                r_full   <= (r_cnt >= i_window);
                r_quo    <= '0;
                r_neg    <= 1'b0;
            end
            S_UPD: begin
                r_neg  <= n_sum[WB-1];
                r_quo  <= n_mag;
                r_rem  <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                r_rem  <= q_bit ? CB'(trial - (CB+1)'(r_cnt)) : CB'(trial);
                r_quo  <= {r_quo[WB-2:0], q_bit};
                r_step <= r_step + bma_pkg::STEP_BITS'(1);
            end
            S_FIN: begin
                if (out_free) begin
                    r_avg  <= sat_avg;
                    r_ocnt <= r_cnt;
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_average      = r_avg;
    assign o_sample_count = r_ocnt;

endmodule
`default_nettype wire

// ----- design/boxcar_moving_average_top.sv -----
// Windowed boxcar average over a ring store with a bit-serial divider.
// An add goes from input accept to result valid through the store access, sum update,
// 22 divider steps and saturate; a clear goes straight from the queue to the result.
// One quotient bit per cycle; the engine pops the next item only once its result is out.
// A two-item input queue and the result register let each side stall on its own.
// Reset is synchronous, active low; the sample store is not cleared and needs none.
`default_nettype none
module boxcar_moving_average_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic                                   i_req_type,
    input  wire logic signed [bma_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [bma_pkg::SAMPLE_BITS-1:0]      o_average,
    output logic [bma_pkg::CNT_BITS-1:0]                o_sample_count,
    input  wire logic                                   i_cfg_we,
    input  wire logic [bma_pkg::CFG_BITS-1:0]           i_cfg_data
);

    logic [bma_pkg::CFG_BITS-1:0] r_window_cfg;
    bma_pkg::t_item               q_item;
    bma_pkg::t_q_status           q_status;
    logic                         q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_cfg <= bma_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_cfg <= i_cfg_data;
        end
    end

    bma_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_sample   (i_sample),
        .o_item     (q_item),
        .o_status   (q_status),
        .i_pop      (q_pop)
    );

    bma_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window       (bma_pkg::eff_window(r_window_cfg)),
        .i_item         (q_item),
        .i_status       (q_status),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_average      (o_average),
        .o_sample_count (o_sample_count)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= bma_pkg::QCNT_BITS'(bma_pkg::QUEUE_DEPTH))
        else $error("input queue over depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sample_count == '0) |-> (o_average == '0))
        else $error("nonzero average from empty window");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_sample_count) <= 32'(bma_pkg::MAX_WINDOW)))
        else $error("sample count above store depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_status.valid)
        else $error("engine popped an empty queue");
`endif

endmodule
`default_nettype wire
